/* src/lli_pkg.sv */
// ----------------------------------------------------------------------------
// lli_pkg
// shared types and constants for the line list insert core
// ----------------------------------------------------------------------------
package lli_pkg;

	localparam int NODES_DEF      = 64;
	localparam int LINE_BYTES_DEF = 64;

	typedef struct packed {
		logic [6:0] line_position;
		logic [7:0] text_char;
		logic       last_char;
	} lli_in_t;

	typedef struct packed {
		logic [5:0] node_index;
		logic       buffer_full;
	} lli_out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_COPY_RD,
		ST_COPY_WR,
		ST_ALLOC,
		ST_FREE,
		ST_HEAD,
		ST_WALK,
		ST_LINK,
		ST_LINK_NODE,
		ST_DONE
	} lli_state_t;

endpackage

/* src/lli_ram.sv */
// ----------------------------------------------------------------------------
// lli_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module lli_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* src/linked_line_list_insert_core.sv */
// ----------------------------------------------------------------------------
// linked_line_list_insert_core
// pool of linked line nodes with free list; stages one line, links it in
// ----------------------------------------------------------------------------
// characters: accepted one per cycle, busy stays low
// last item: the staged line is copied into the node's text, the node is taken
//   from the free list and put at the head or linked in after a walk to its
//   position, none of this when full; done is high in the same cycle busy falls
// reset clears control state, the link ram starts as the initial chain through
//   a valid flag per node, text memories need none
module linked_line_list_insert_core #(
	parameter int NODES      = lli_pkg::NODES_DEF,
	parameter int LINE_BYTES = lli_pkg::LINE_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  lli_pkg::lli_in_t   item,
	output logic               busy,
	output logic               done,
	output lli_pkg::lli_out_t  result
);
	import lli_pkg::*;

	localparam int NW = $clog2(NODES + 1);
	localparam int NI = $clog2(NODES);
	localparam int BW = $clog2(LINE_BYTES);
	localparam int TA = $clog2(NODES * LINE_BYTES);
	localparam logic [NW-1:0] NIL = NW'(NODES);

	lli_state_t state_q, state_d;

	logic [NODES-1:0] nval_q;
	logic [NW-1:0] pool_top_q, used_head_q, node_q, cur_q, after_q, rd_addr_q;
	logic          rd_val_q;
	logic [BW:0]   staged_cnt_q, idx_q;
	logic          ended_q;
	logic [6:0]    pos_q, step_q;
	logic [NW-1:0] nxt_cur;
	logic          walk_on;

	logic          lk_we;
	logic [NW-1:0] lk_waddr, lk_wdata, lk_raddr, lk_rdata;

	logic          sw_we;
	logic [7:0]    sw_rdata;
	logic          tw_we;
	logic [7:0]    tw_data;
	logic [7:0]    tw_rdata;

	wire accept = start && !busy;
	wire take   = accept && !ended_q && item.text_char != 8'd0
		&& staged_cnt_q < (BW+1)'(LINE_BYTES - 1);

	// unwritten link entries read as the initial chain
	assign nxt_cur = rd_val_q ? lk_rdata : NW'(rd_addr_q + 1'b1);
	assign walk_on = step_q + 7'd1 < pos_q && nxt_cur != NIL;
	assign sw_we   = take;

	always_comb begin
		lk_we    = 1'b0;
		lk_waddr = node_q;
		lk_wdata = NIL;
		lk_raddr = cur_q;
		case (state_q)
			ST_ALLOC: lk_raddr = node_q;
			ST_FREE:  lk_raddr = used_head_q;
			ST_WALK:  lk_raddr = nxt_cur;
			ST_HEAD: begin
				lk_we    = 1'b1;
				lk_waddr = node_q;
				lk_wdata = used_head_q;
			end
			ST_LINK: begin
				lk_we    = 1'b1;
				lk_waddr = cur_q;
				lk_wdata = node_q;
			end
			ST_LINK_NODE: begin
				lk_we    = 1'b1;
				lk_waddr = node_q;
				lk_wdata = after_q;
			end
			default: ;
		endcase
	end

	lli_ram #(.WIDTH(NW), .DEPTH(NODES)) u_link (
		.clk(clk), .we(lk_we), .waddr(lk_waddr[NI-1:0]),
		.wdata(lk_wdata), .raddr(lk_raddr[NI-1:0]), .rdata(lk_rdata));

	lli_ram #(.WIDTH(8), .DEPTH(LINE_BYTES)) u_stage (
		.clk(clk), .we(sw_we), .waddr(staged_cnt_q[BW-1:0]),
		.wdata(item.text_char), .raddr(idx_q[BW-1:0]), .rdata(sw_rdata));

	assign tw_we   = state_q == ST_COPY_WR;
	assign tw_data = (idx_q <= staged_cnt_q && idx_q != '0) ? sw_rdata : 8'd0;

	lli_ram #(.WIDTH(8), .DEPTH(NODES * LINE_BYTES)) u_text (
		.clk(clk), .we(tw_we),
		.waddr(TA'(node_q[NI-1:0] * LINE_BYTES + (idx_q - 1'b1))),
		.wdata(tw_data), .raddr('0), .rdata(tw_rdata));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = state_q != ST_IDLE;
		case (state_q)
			ST_IDLE:    if (accept && item.last_char) begin
				state_d = pool_top_q == NIL ? ST_DONE : ST_COPY_RD;
			end
			ST_COPY_RD: state_d = ST_COPY_WR;
			ST_COPY_WR: state_d = idx_q == (BW+1)'(LINE_BYTES) ? ST_ALLOC : ST_COPY_RD;
			ST_ALLOC:   state_d = ST_FREE;
			ST_FREE:    state_d = (pos_q == 7'd0 || used_head_q == NIL) ? ST_HEAD : ST_WALK;
			ST_HEAD:    state_d = ST_DONE;
			ST_WALK:    if (!walk_on) begin
				state_d = ST_LINK;
			end
			ST_LINK:      state_d = ST_LINK_NODE;
			ST_LINK_NODE: state_d = ST_DONE;
			ST_DONE:      state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nval_q       <= '0;
			pool_top_q   <= '0;
			used_head_q  <= NIL;
			staged_cnt_q <= '0;
			ended_q      <= 1'b0;
			done         <= 1'b0;
			result       <= '0;
			idx_q        <= '0;
			pos_q        <= '0;
			node_q       <= '0;
			cur_q        <= '0;
			after_q      <= '0;
			step_q       <= '0;
			rd_addr_q    <= '0;
			rd_val_q     <= 1'b0;
		end else begin
			done      <= 1'b0;
			rd_addr_q <= lk_raddr;
			rd_val_q  <= nval_q[lk_raddr[NI-1:0]];
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (take) begin
							staged_cnt_q <= staged_cnt_q + 1'b1;
						end
						if (!ended_q && item.text_char == 8'd0) begin
							ended_q <= 1'b1;
						end
						if (item.last_char) begin
							pos_q <= item.line_position;
							node_q <= pool_top_q;
							idx_q <= '0;
						end
					end
				end
				ST_COPY_RD: idx_q <= idx_q + 1'b1;
				ST_COPY_WR: ;
				ST_ALLOC: ;
				ST_FREE: begin
					pool_top_q <= nxt_cur;
					cur_q      <= used_head_q;
					step_q     <= '0;
				end
				ST_HEAD: begin
					nval_q[node_q[NI-1:0]] <= 1'b1;
					used_head_q <= node_q;
				end
				ST_WALK: begin
					if (walk_on) begin
						cur_q  <= nxt_cur;
						step_q <= step_q + 7'd1;
					end else begin
						after_q <= nxt_cur;
					end
				end
				ST_LINK: begin
					nval_q[cur_q[NI-1:0]] <= 1'b1;
				end
				ST_LINK_NODE: begin
					nval_q[node_q[NI-1:0]] <= 1'b1;
				end
				ST_DONE: begin
					done <= 1'b1;
					result.buffer_full <= pool_top_q == NIL && node_q == NIL;
					result.node_index  <= node_q == NIL ? 6'd0 : 6'(node_q);
					staged_cnt_q <= '0;
					ended_q      <= 1'b0;
				end
				default: ;
			endcase
		end
	end

endmodule

/* src/lli_checker.sv */
// ----------------------------------------------------------------------------
// lli_checker
// port level checks for the line list insert core
// ----------------------------------------------------------------------------
module lli_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input lli_pkg::lli_in_t  item,
	input logic              busy,
	input logic              done,
	input lli_pkg::lli_out_t result
);
	import lli_pkg::*;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held two cycles");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("done without work");
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.buffer_full |-> result.node_index == 6'd0)
		else $error("full with index");
	a_idle_after: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("busy after result");
	a_char_ready: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !item.last_char |=> !busy) else $error("busy after character");

endmodule

bind linked_line_list_insert_core lli_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .item(item), .busy(busy),
	.done(done), .result(result));

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the line list insert core: streams text items in
// bursts, predicts the node taken from the free list and the full flag, and
// checks every result strobe against the oldest prediction
// ----------------------------------------------------------------------------
module tb_top;
	import lli_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NODES      = NODES_DEF;
	localparam int LINE_BYTES = LINE_BYTES_DEF;
	localparam int NIL        = NODES;
	localparam int STALL_MAX  = 20000;

	logic     clk;
	logic     arst_n;
	logic     start;
	lli_in_t  item;
	logic     busy;
	logic     done;
	lli_out_t result;

	linked_line_list_insert_core #(.NODES(NODES), .LINE_BYTES(LINE_BYTES)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item),
		.busy(busy), .done(done), .result(result)
	);

	always #6 clk = ~clk;

	lli_in_t  pending_items[$];
	lli_out_t expected_nodes[$];
	int       n_errors = 0;
	int       n_lines = 0;
	int       n_results;
	int       idle_cycles;

	// list state for prediction
	int next_lnk[NODES];
	int pool_top;
	int used_head;

	function automatic lli_out_t predict_insert(lli_in_t it);
		lli_out_t r;
		int node, cur, after, i;
		r = '0;
		if (pool_top >= NODES) begin
			r.buffer_full = 1'b1;
			return r;
		end
		node = pool_top;
		pool_top = next_lnk[node];
		next_lnk[node] = NIL;
		if (it.line_position == 0 || used_head >= NODES) begin
			next_lnk[node] = used_head;
			used_head = node;
		end else begin
			cur = used_head;
			for (i = 0; i + 1 < it.line_position && next_lnk[cur] < NODES; i++)
				cur = next_lnk[cur];
			after = next_lnk[cur];
			next_lnk[cur] = node;
			next_lnk[node] = after;
		end
		r.node_index = node[5:0];
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		n_errors++;
	endtask

	task automatic push_line(int len, int zero_at, int pos);
		lli_in_t it;
		for (int k = 0; k < len; k++) begin
			it.line_position = 7'($urandom_range(0, 127));
			it.text_char = (k == zero_at) ? 8'd0 : 8'($urandom_range(1, 255));
			it.last_char = (k == len - 1);
			if (k == len - 1) begin
				it.line_position = 7'(pos);
				n_lines++;
			end
			pending_items.push_back(it);
		end
	endtask

	// driver: bursts with gaps
	int burst_left, gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			item <= '0;
			burst_left <= 0;
			gap_left <= 0;
			for (int i = 0; i < NODES; i++)
				next_lnk[i] = i + 1;
			pool_top = 0;
			used_head = NIL;
		end else begin
			if (start && !busy) begin
				if (item.last_char)
					expected_nodes.push_back(predict_insert(item));
			end
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					start <= 1'b0;
				end else if (pending_items.size() > 0) begin
					item <= pending_items.pop_front();
					start <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
			n_results <= 0;
		end else begin
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (done) begin
				n_results <= n_results + 1;
				if (expected_nodes.size() == 0) begin
					report_mismatch("result with nothing expected");
				end else begin
					lli_out_t e;
					e = expected_nodes.pop_front();
					if (result.node_index !== e.node_index)
						report_mismatch($sformatf("node_index %0d, expected %0d",
							result.node_index, e.node_index));
					if (result.buffer_full !== e.buffer_full)
						report_mismatch($sformatf("buffer_full %0b, expected %0b",
							result.buffer_full, e.buffer_full));
				end
			end
			if (idle_cycles > STALL_MAX) begin
				$display("linked_line_list_insert_core regression: fail");
				$finish;
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;

		// directed: extremes, zero byte, long line, tail append
		push_line(1, -1, 0);
		push_line(1, 0, 127);
		push_line(3, 1, 1);
		push_line(LINE_BYTES + 3, -1, 64);
		push_line(2, -1, 2);
		push_line(4, 0, 1);
		push_line(1, -1, 100);

		// random lines, mostly short; fills the pool and overflows it
		while (pending_items.size() < 1100) begin
			int len, zero_at, pos;
			len = ($urandom_range(0, 15) == 0) ? $urandom_range(30, LINE_BYTES + 4)
			                                    : $urandom_range(1, 5);
			zero_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1) : -1;
			case ($urandom_range(0, 3))
				0: pos = 0;
				1: pos = $urandom_range(65, 127);
				default: pos = $urandom_range(1, 70);
			endcase
			push_line(len, zero_at, pos);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_items.size() == 0 && n_results == n_lines);
		repeat (2 * LINE_BYTES + 2 * NODES + 20) @(posedge clk);
		if (n_errors == 0 && expected_nodes.size() == 0)
			$display("linked_line_list_insert_core regression: pass");
		else
			$display("linked_line_list_insert_core regression: fail");
		$finish;
	end
endmodule
